### sv/ihq_pkg.sv
`default_nettype none
package ihq_pkg;

    localparam int MAX_ITEMS = 1024;
    localparam int KEY_BITS  = 32;

    localparam int SLOT_W = $clog2(MAX_ITEMS);
    localparam int CNT_W  = SLOT_W + 1;
    localparam int MAP_W  = SLOT_W + 1;

    localparam int MODE_W   = 2;
    localparam int ID_W     = 10;
    localparam int KEY_W    = 32;
    localparam int STATUS_W = 3;
    localparam int OCC_W    = 11;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 56;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_POP    = 2'd1,
        MODE_DELETE = 2'd2
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK     = 3'd0,
        STAT_EMPTY  = 3'd1,
        STAT_FULL   = 3'd2,
        STAT_DUP    = 3'd3,
        STAT_ABSENT = 3'd4
    } status_t;

    typedef struct packed {
        status_t           status;
        logic [ID_W-1:0]   out_id;
        logic [KEY_W-1:0]  out_key;
        logic [OCC_W-1:0]  occupancy;
    } result_t;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        logic [SLOT_W-1:0] wdata;
        logic [SLOT_W-1:0] ra0;
        logic [SLOT_W-1:0] ra1;
    } heap_req_t;

    typedef struct packed {
        logic                we;
        logic [SLOT_W-1:0]   waddr;
        logic [KEY_BITS-1:0] wdata;
        logic [SLOT_W-1:0]   ra0;
        logic [SLOT_W-1:0]   ra1;
    } key_req_t;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        logic [MAP_W-1:0]  wdata;
        logic [SLOT_W-1:0] ra0;
    } map_req_t;

endpackage
`default_nettype wire

### sv/ihq_ram.sv
`default_nettype none
module ihq_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    ra0,
    input  wire logic [AW-1:0]    ra1,
    output logic      [WIDTH-1:0] rd0,
    output logic      [WIDTH-1:0] rd1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd0 <= mem[ra0];
        rd1 <= mem[ra1];
    end

endmodule
`default_nettype wire

### sv/ihq_ctrl.sv
`default_nettype none
module ihq_ctrl (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [ihq_pkg::MODE_W-1:0]   in_mode,
    input  wire logic [ihq_pkg::ID_W-1:0]     in_id,
    input  wire logic [ihq_pkg::KEY_W-1:0]    in_key,
    output logic                              res_valid,
    input  wire logic                         res_ready,
    output ihq_pkg::result_t                  res,
    output ihq_pkg::heap_req_t                heap_req,
    input  wire logic [ihq_pkg::SLOT_W-1:0]   heap_rd0,
    input  wire logic [ihq_pkg::SLOT_W-1:0]   heap_rd1,
    output ihq_pkg::key_req_t                 key_req,
    input  wire logic [ihq_pkg::KEY_BITS-1:0] key_rd0,
    input  wire logic [ihq_pkg::KEY_BITS-1:0] key_rd1,
    output ihq_pkg::map_req_t                 map_req,
    input  wire logic [ihq_pkg::MAP_W-1:0]    map_rd
);
    import ihq_pkg::*;

    typedef enum logic [15:0] {
        ST_CLR     = 16'h0001,
        ST_IDLE    = 16'h0002,
        ST_INS_CHK = 16'h0004,
        ST_RISE    = 16'h0008,
        ST_RISE_P  = 16'h0010,
        ST_RISE_K  = 16'h0020,
        ST_RM_ID   = 16'h0040,
        ST_DEL_CHK = 16'h0080,
        ST_RM_KEY  = 16'h0100,
        ST_DOWN    = 16'h0200,
        ST_DN_ID   = 16'h0400,
        ST_DN_KEY  = 16'h0800,
        ST_DN_ONE  = 16'h1000,
        ST_FILL    = 16'h2000,
        ST_FILL_K  = 16'h4000,
        ST_DONE    = 16'h8000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [SLOT_W-1:0]   clr_reg, clr_next;
    logic [SLOT_W-1:0]   id_reg, id_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [SLOT_W-1:0]   hole_reg, hole_next;
    logic [SLOT_W-1:0]   pid_reg, pid_next;
    logic [SLOT_W-1:0]   cur_id_reg, cur_id_next;
    logic [KEY_BITS-1:0] cur_key_reg, cur_key_next;
    logic [SLOT_W-1:0]   lid_reg, lid_next;
    logic [SLOT_W-1:0]   rgt_reg, rgt_next;
    status_t             status_reg, status_next;
    logic [SLOT_W-1:0]   rid_reg, rid_next;
    logic [KEY_BITS-1:0] rkey_reg, rkey_next;

    logic                id_ok;
    logic [SLOT_W-1:0]   parent;
    logic [CNT_W:0]      left_w, right_w;
    logic [CNT_W-1:0]    cnt_dec;

    assign id_ok   = 32'(in_id) < 32'(MAX_ITEMS);
    assign parent  = (slot_reg - SLOT_W'(1)) >> 1;
    assign left_w  = {1'b0, hole_reg, 1'b1};
    assign right_w = left_w + (CNT_W+1)'(1);
    assign cnt_dec = cnt_reg - CNT_W'(1);

    assign in_ready      = (state_reg == ST_IDLE);
    assign res_valid     = (state_reg == ST_DONE);
    assign res.status    = status_reg;
    assign res.out_id    = ID_W'(rid_reg);
    assign res.out_key   = KEY_W'(rkey_reg);
    assign res.occupancy = OCC_W'(cnt_reg);

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        clr_next     = clr_reg;
        id_next      = id_reg;
        key_next     = key_reg;
        slot_next    = slot_reg;
        hole_next    = hole_reg;
        pid_next     = pid_reg;
        cur_id_next  = cur_id_reg;
        cur_key_next = cur_key_reg;
        lid_next     = lid_reg;
        rgt_next     = rgt_reg;
        status_next  = status_reg;
        rid_next     = rid_reg;
        rkey_next    = rkey_reg;
        heap_req     = '0;
        key_req      = '0;
        map_req      = '0;
        map_req.ra0  = SLOT_W'(in_id);

        unique case (state_reg)
            ST_CLR:
            begin
                map_req.we    = 1'b1;
                map_req.waddr = clr_reg;
                clr_next      = clr_reg + SLOT_W'(1);
                if (clr_reg == SLOT_W'(MAX_ITEMS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    id_next     = SLOT_W'(in_id);
                    key_next    = KEY_BITS'(in_key);
                    status_next = STAT_OK;
                    rid_next    = '0;
                    rkey_next   = '0;
                    case (in_mode)
                        MODE_INSERT:
                        begin
                            if (!id_ok)
                            begin
                                status_next = STAT_FULL;
                                state_next  = ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_INS_CHK;
                            end
                        end
                        MODE_POP:
                        begin
                            if (cnt_reg == '0)
                            begin
                                status_next = STAT_EMPTY;
                                state_next  = ST_DONE;
                            end
                            else
                            begin
                                hole_next  = '0;
                                state_next = ST_RM_ID;
                            end
                        end
                        MODE_DELETE:
                        begin
                            if (!id_ok)
                            begin
                                status_next = STAT_ABSENT;
                                state_next  = ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_DEL_CHK;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_INS_CHK:
            begin
                if (map_rd[SLOT_W])
                begin
                    status_next = STAT_DUP;
                    state_next  = ST_DONE;
                end
                else if (cnt_reg == CNT_W'(MAX_ITEMS))
                begin
                    status_next = STAT_FULL;
                    state_next  = ST_DONE;
                end
                else
                begin
                    key_req.we    = 1'b1;
                    key_req.waddr = id_reg;
                    key_req.wdata = key_reg;
                    cnt_next      = cnt_reg + CNT_W'(1);
                    slot_next     = cnt_reg[SLOT_W-1:0];
                    cur_id_next   = id_reg;
                    cur_key_next  = key_reg;
                    state_next    = ST_RISE;
                end
            end
            ST_RISE:
            begin
                if (slot_reg == '0)
                begin
                    heap_req.we    = 1'b1;
                    heap_req.waddr = slot_reg;
                    heap_req.wdata = cur_id_reg;
                    map_req.we     = 1'b1;
                    map_req.waddr  = cur_id_reg;
                    map_req.wdata  = {1'b1, slot_reg};
                    state_next     = ST_DONE;
                end
                else
                begin
                    heap_req.ra0 = parent;
                    state_next   = ST_RISE_P;
                end
            end
            ST_RISE_P:
            begin
                pid_next    = heap_rd0;
                key_req.ra0 = heap_rd0;
                state_next  = ST_RISE_K;
            end
            ST_RISE_K:
            begin
                heap_req.we    = 1'b1;
                heap_req.waddr = slot_reg;
                map_req.we     = 1'b1;
                map_req.wdata  = {1'b1, slot_reg};
                // The new entry rises past parents with an equal key.
                if (cur_key_reg > key_rd0)
                begin
                    heap_req.wdata = cur_id_reg;
                    map_req.waddr  = cur_id_reg;
                    state_next     = ST_DONE;
                end
                else
                begin
                    heap_req.wdata = pid_reg;
                    map_req.waddr  = pid_reg;
                    slot_next      = parent;
                    state_next     = ST_RISE;
                end
            end
            ST_RM_ID:
            begin
                rid_next    = heap_rd0;
                key_req.ra0 = heap_rd0;
                state_next  = ST_RM_KEY;
            end
            ST_DEL_CHK:
            begin
                if (!map_rd[SLOT_W] || ({1'b0, map_rd[SLOT_W-1:0]} >= cnt_reg))
                begin
                    status_next = STAT_ABSENT;
                    state_next  = ST_DONE;
                end
                else
                begin
                    hole_next   = map_rd[SLOT_W-1:0];
                    rid_next    = id_reg;
                    key_req.ra0 = id_reg;
                    state_next  = ST_RM_KEY;
                end
            end
            ST_RM_KEY:
            begin
                rkey_next     = key_rd0;
                map_req.we    = 1'b1;
                map_req.waddr = rid_reg;
                map_req.wdata = '0;
                state_next    = ST_DOWN;
            end
            ST_DOWN:
            begin
                if (right_w < {1'b0, cnt_reg})
                begin
                    heap_req.ra0 = left_w[SLOT_W-1:0];
                    heap_req.ra1 = right_w[SLOT_W-1:0];
                    state_next   = ST_DN_ID;
                end
                else if (left_w < {1'b0, cnt_reg})
                begin
                    heap_req.ra0 = left_w[SLOT_W-1:0];
                    state_next   = ST_DN_ONE;
                end
                else
                begin
                    cnt_next = cnt_dec;
                    if ({1'b0, hole_reg} < cnt_dec)
                    begin
                        heap_req.ra0 = cnt_dec[SLOT_W-1:0];
                        state_next   = ST_FILL;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DN_ID:
            begin
                lid_next    = heap_rd0;
                rgt_next    = heap_rd1;
                key_req.ra0 = heap_rd0;
                key_req.ra1 = heap_rd1;
                state_next  = ST_DN_KEY;
            end
            ST_DN_KEY:
            begin
                heap_req.we    = 1'b1;
                heap_req.waddr = hole_reg;
                map_req.we     = 1'b1;
                map_req.wdata  = {1'b1, hole_reg};
                // On equal keys the right child moves up.
                if (key_rd0 < key_rd1)
                begin
                    heap_req.wdata = lid_reg;
                    map_req.waddr  = lid_reg;
                    hole_next      = left_w[SLOT_W-1:0];
                end
                else
                begin
                    heap_req.wdata = rgt_reg;
                    map_req.waddr  = rgt_reg;
                    hole_next      = right_w[SLOT_W-1:0];
                end
                state_next = ST_DOWN;
            end
            ST_DN_ONE:
            begin
                heap_req.we    = 1'b1;
                heap_req.waddr = hole_reg;
                heap_req.wdata = heap_rd0;
                map_req.we     = 1'b1;
                map_req.waddr  = heap_rd0;
                map_req.wdata  = {1'b1, hole_reg};
                cnt_next       = cnt_dec;
                state_next     = ST_DONE;
            end
            ST_FILL:
            begin
                cur_id_next = heap_rd0;
                key_req.ra0 = heap_rd0;
                state_next  = ST_FILL_K;
            end
            ST_FILL_K:
            begin
                cur_key_next = key_rd0;
                slot_next    = hole_reg;
                state_next   = ST_RISE;
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLR;
            cnt_reg   <= '0;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg      <= id_next;
        key_reg     <= key_next;
        slot_reg    <= slot_next;
        hole_reg    <= hole_next;
        pid_reg     <= pid_next;
        cur_id_reg  <= cur_id_next;
        cur_key_reg <= cur_key_next;
        lid_reg     <= lid_next;
        rgt_reg     <= rgt_next;
        status_reg  <= status_next;
        rid_reg     <= rid_next;
        rkey_reg    <= rkey_next;
    end

endmodule
`default_nettype wire

### sv/indexed_min_heap_queue_unit.sv
// Indexed min-heap queue of item ids ordered by an unsigned Q16.16 key.
// Input channel s_*: one transfer is one operation. s_tuser carries the mode
// (insert, pop minimum, delete by id); s_tdata carries item_id and key.
// Output channel m_*: exactly one result transfer per operation, in order.
// m_tuser carries the status; m_tdata carries out_id, out_key and occupancy.
// An accepted insert lets its entry rise level by level until it ends at the
// root or below a smaller key. A pop or delete walks the hole down one level
// at a time and then lets the last entry refill the hole and rise. Each level
// is a read-modify-write walk over the heap memory, whose reads are
// registered: a slot read, a key read and a write back.
// One operation is worked on at a time; the next transfer is taken the cycle
// after the result moves into the output register, even while the receiver
// stalls. A stalled result holds in the output register until m_tready.
// After reset the queued-id map is cleared in a pass over all 1024 entries,
// during which s_tready stays low.
`default_nettype none
module indexed_min_heap_queue_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // item_id [9:0], key [41:10], zero fill above
    input  wire logic [ihq_pkg::IN_DATA_W-1:0]     s_tdata,
    // mode [1:0]
    input  wire logic [ihq_pkg::MODE_W-1:0]        s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // out_id [9:0], out_key [41:10], occupancy [52:42], zero fill above
    output logic [ihq_pkg::OUT_DATA_W-1:0]         m_tdata,
    // status [2:0]
    output logic [ihq_pkg::STATUS_W-1:0]           m_tuser
);
    import ihq_pkg::*;

    result_t             res;
    logic                res_valid;
    logic                res_ready;
    heap_req_t           heap_req;
    key_req_t            key_req;
    map_req_t            map_req;
    logic [SLOT_W-1:0]   heap_rd0, heap_rd1;
    logic [KEY_BITS-1:0] key_rd0, key_rd1;
    logic [MAP_W-1:0]    map_rd;
    logic                out_valid_reg;
    result_t             out_res_reg;

    assign res_ready = !out_valid_reg || m_tready;

    ihq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_mode  (s_tuser),
        .in_id    (s_tdata[ID_W-1:0]),
        .in_key   (s_tdata[ID_W+KEY_W-1:ID_W]),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res      (res),
        .heap_req (heap_req),
        .heap_rd0 (heap_rd0),
        .heap_rd1 (heap_rd1),
        .key_req  (key_req),
        .key_rd0  (key_rd0),
        .key_rd1  (key_rd1),
        .map_req  (map_req),
        .map_rd   (map_rd)
    );

    ihq_ram #(.DEPTH(MAX_ITEMS), .WIDTH(SLOT_W)) u_heap_ram (
        .clk  (clk),
        .we   (heap_req.we),
        .waddr(heap_req.waddr),
        .wdata(heap_req.wdata),
        .ra0  (heap_req.ra0),
        .ra1  (heap_req.ra1),
        .rd0  (heap_rd0),
        .rd1  (heap_rd1)
    );

    ihq_ram #(.DEPTH(MAX_ITEMS), .WIDTH(KEY_BITS)) u_key_ram (
        .clk  (clk),
        .we   (key_req.we),
        .waddr(key_req.waddr),
        .wdata(key_req.wdata),
        .ra0  (key_req.ra0),
        .ra1  (key_req.ra1),
        .rd0  (key_rd0),
        .rd1  (key_rd1)
    );

    // Slot map: queued flag in the top bit, heap slot below it.
    ihq_ram #(.DEPTH(MAX_ITEMS), .WIDTH(MAP_W)) u_map_ram (
        .clk  (clk),
        .we   (map_req.we),
        .waddr(map_req.waddr),
        .wdata(map_req.wdata),
        .ra0  (map_req.ra0),
        .ra1  (map_req.ra0),
        .rd0  (map_rd),
        .rd1  ()
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.status;
    assign m_tdata  = {(OUT_DATA_W-ID_W-KEY_W-OCC_W)'(0), out_res_reg.occupancy,
                       out_res_reg.out_key, out_res_reg.out_id};

endmodule
`default_nettype wire

### sv/ihq_checker.sv
`default_nettype none
module ihq_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [ihq_pkg::OUT_DATA_W-1:0] m_tdata,
    input wire logic [ihq_pkg::STATUS_W-1:0]  m_tuser
);
    import ihq_pkg::*;

    // A stalled result must hold.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Only one operation is in flight, so input is refused right after a transfer.
    a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an operation is in flight");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser <= STAT_ABSENT)
        else $error("status code out of range");

    // A failed operation removes nothing.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != STAT_OK |-> m_tdata[ID_W+KEY_W-1:0] == '0)
        else $error("failed operation reports a removed entry");

    a_occ: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[ID_W+KEY_W+OCC_W-1:ID_W+KEY_W] <= OCC_W'(MAX_ITEMS))
        else $error("occupancy beyond capacity");

endmodule

bind indexed_min_heap_queue_unit ihq_checker u_ihq_checker (.*);
`default_nettype wire

### tb/tb_indexed_min_heap_queue_unit.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_indexed_min_heap_queue_unit;
    import ihq_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 200;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    class heap_scoreboard;
        logic [ID_W-1:0]  heap_id [MAX_ITEMS];
        logic [KEY_W-1:0] key_of [MAX_ITEMS];
        int               slot_of [MAX_ITEMS];
        bit               queued [MAX_ITEMS];
        int               count;
        result_t          pending [$];
        int               errors;
        int               checked;

        function void clear();
            for (int i = 0; i < MAX_ITEMS; i++)
            begin
                heap_id[i] = '0;
                key_of[i] = '0;
                slot_of[i] = 0;
                queued[i] = 0;
            end
            count = 0;
            errors = 0;
            checked = 0;
            pending.delete();
        endfunction

        function void place(int slot, logic [ID_W-1:0] id);
            heap_id[slot] = id;
            slot_of[id] = slot;
        endfunction

        function void sift_up(int slot);
            logic [ID_W-1:0]  id;
            logic [KEY_W-1:0] k;
            int               parent;
            id = heap_id[slot];
            k = key_of[id];
            while (slot > 0)
            begin
                parent = (slot - 1) / 2;
                if (k > key_of[heap_id[parent]])
                    break;
                place(slot, heap_id[parent]);
                slot = parent;
            end
            place(slot, id);
        endfunction

        function void remove_at(int hole);
            int left;
            int last;
            queued[heap_id[hole]] = 0;
            forever
            begin
                left = hole * 2 + 1;
                if (left + 1 < count)
                begin
                    if (key_of[heap_id[left]] < key_of[heap_id[left + 1]])
                    begin
                        place(hole, heap_id[left]);
                        hole = left;
                    end
                    else
                    begin
                        place(hole, heap_id[left + 1]);
                        hole = left + 1;
                    end
                end
                else if (left < count)
                begin
                    place(hole, heap_id[left]);
                    count--;
                    return;
                end
                else
                begin
                    last = count - 1;
                    count--;
                    if (hole < last)
                    begin
                        place(hole, heap_id[last]);
                        sift_up(hole);
                    end
                    return;
                end
            end
        endfunction

        function void note_operation(logic [1:0] mode, logic [ID_W-1:0] id,
                                     logic [KEY_W-1:0] key);
            result_t r;
            r = '0;
            r.status = STAT_OK;
            if (mode == MODE_INSERT)
            begin
                if (queued[id])
                    r.status = STAT_DUP;
                else if (count >= MAX_ITEMS)
                    r.status = STAT_FULL;
                else
                begin
                    key_of[id] = key;
                    queued[id] = 1;
                    place(count, id);
                    count++;
                    sift_up(count - 1);
                end
            end
            else if (mode == MODE_POP)
            begin
                if (count == 0)
                    r.status = STAT_EMPTY;
                else
                begin
                    r.out_id = heap_id[0];
                    r.out_key = key_of[heap_id[0]];
                    remove_at(0);
                end
            end
            else if (mode == MODE_DELETE)
            begin
                if (!queued[id] || slot_of[id] >= count)
                    r.status = STAT_ABSENT;
                else
                begin
                    r.out_id = id;
                    r.out_key = key_of[id];
                    remove_at(slot_of[id]);
                end
            end
            r.occupancy = count[OCC_W-1:0];
            pending.push_back(r);
        endfunction

        function void check_result(logic [STATUS_W-1:0] status, logic [ID_W-1:0] id,
                                   logic [KEY_W-1:0] key, logic [OCC_W-1:0] occ);
            result_t e;
            checked++;
            if (pending.size() == 0)
            begin
                $error("result transfer with nothing expected");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (status != e.status)
            begin
                $error("status: expected %0d, got %0d", e.status, status);
                errors++;
            end
            if (id != e.out_id)
            begin
                $error("out_id: expected %0d, got %0d", e.out_id, id);
                errors++;
            end
            if (key != e.out_key)
            begin
                $error("out_key: expected %h, got %h", e.out_key, key);
                errors++;
            end
            if (occ != e.occupancy)
            begin
                $error("occupancy: expected %0d, got %0d", e.occupancy, occ);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [MODE_W-1:0]     s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]   m_tuser;

    heap_scoreboard sb;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  cycles;
    int  sent;

    indexed_min_heap_queue_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    initial
    begin
        sb = new();
        sb.clear();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        sent = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Checking and receiver stalls, sampled at the edge where the transfer happens.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tuser, m_tdata[9:0], m_tdata[41:10], m_tdata[52:42]);
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end
    initial cycles = 0;

    // tvalid stays high into the next operation when no idle cycle follows.
    task automatic send_op(input logic [1:0] mode, input logic [ID_W-1:0] id,
                           input logic [KEY_W-1:0] key);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= {6'b0, key, id};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_operation(mode, id, key);
        sent++;
    endtask

    // Nearly half inserts while the heap holds 40 entries or fewer, mostly removals beyond that.
    task automatic random_op();
        int   pick;
        logic [KEY_W-1:0] k;
        pick = $urandom_range(99);
        case ($urandom_range(3))
            0: k = $urandom_range(15);
            1: k = 32'hFFFF_FFF0 | $urandom_range(15);
            default: k = $urandom;
        endcase
        if (pick < 3)
            send_op(MODE_UNUSED, ID_W'($urandom), $urandom);
        else if (pick < 50 - (sb.count > 40 ? 15 : 0))
            send_op(MODE_INSERT, ID_W'($urandom_range(1023)), k);
        else if (pick < 75)
            send_op(MODE_POP, ID_W'($urandom), $urandom);
        else
            send_op(MODE_DELETE, ID_W'($urandom_range(1023)), $urandom);
    endtask

    initial
    begin
        @(posedge rst_n);
        @(posedge clk);
        // Directed: empty pop, absent delete, extreme keys, equal keys, reinsert.
        send_op(MODE_POP, 10'd0, 32'd0);
        send_op(MODE_DELETE, 10'd1023, 32'd0);
        send_op(MODE_INSERT, 10'd1023, 32'hFFFF_FFFF);
        send_op(MODE_INSERT, 10'd0, 32'd0);
        send_op(MODE_INSERT, 10'd5, 32'd7);
        send_op(MODE_INSERT, 10'd6, 32'd7);
        send_op(MODE_INSERT, 10'd7, 32'd7);
        send_op(MODE_INSERT, 10'd0, 32'd9);
        send_op(MODE_UNUSED, 10'h3FF, 32'hFFFF_FFFF);
        send_op(MODE_DELETE, 10'd6, 32'd0);
        send_op(MODE_POP, 10'd0, 32'd0);
        send_op(MODE_POP, 10'd0, 32'd0);
        send_op(MODE_DELETE, 10'd6, 32'd0);
        send_op(MODE_POP, 10'd0, 32'd0);
        send_op(MODE_POP, 10'd0, 32'd0);
        send_op(MODE_POP, 10'd0, 32'd0);
        send_phase(32, 81, 330);
        send_phase(81, 32, 330);
        send_phase(0, 0, 330);
        // Drain to empty so that every remaining entry leaves by a pop.
        while (sb.count > 0)
            send_op(MODE_POP, 10'd0, 32'd0);
        s_tvalid <= 1'b0;
        while (sb.pending.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("%0d operations sent, %0d results checked, in three stall mixes", sent,
                 sb.checked);
        $display("ending with a drain of the queue to empty");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic send_phase(input int send_pct, input int recv_pct, input int n);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int i = 0; i < n; i++)
            random_op();
    endtask

endmodule
`default_nettype wire
